// File: design/mcv_pkg.sv
// Shared types and constants for the multichannel convolution engine.
// No dependencies.
`default_nettype none
package mcv_pkg;
   typedef enum logic [1:0] {
      CMD_PIXEL  = 2'd0,
      CMD_WEIGHT = 2'd1,
      CMD_BIAS   = 2'd2,
      CMD_CALC   = 2'd3
   } cmd_type;

   localparam logic [1:0] CSR_KERNEL = 2'd0;
   localparam logic [1:0] CSR_SIDE   = 2'd1;
   localparam logic [1:0] CSR_MAPS   = 2'd2;

   // one command as it travels from front to back
   typedef struct packed {
      cmd_type     command;
      logic [1:0]  in_map;
      logic [2:0]  out_map;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [31:0] value;
   } item_type;
endpackage
`default_nettype wire

// File: design/mcv_front.sv
// Front end: accepts command beats into a short queue.
// Depends on mcv_pkg.
`default_nettype none
module mcv_front (
   input  wire              clock,
   input  wire              reset,
   input  wire              in_valid,
   output logic             in_stall,
   input  mcv_pkg::item_type in_item,
   output logic             q_valid,
   input  wire              q_take,
   output mcv_pkg::item_type q_item
);
   import mcv_pkg::*;

   item_type   mem_ff [4];
   logic [1:0] wr_ff, rd_ff;
   logic [2:0] cnt_ff;
   logic       push, pop;

   assign in_stall = (cnt_ff == 3'd4);
   assign push     = in_valid && !in_stall;
   assign q_valid  = (cnt_ff != 3'd0);
   assign pop      = q_valid && q_take;
   assign q_item   = mem_ff[rd_ff];

   // store beat
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 2'd1;
         if (pop)  rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 3'd4)
      else $error("queue count overflow");
   no_push_full: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 3'd4) |-> !push) else $error("push into full queue");
   pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (cnt_ff != 3'd0)) else $error("pop from empty queue");
endmodule
`default_nettype wire

// File: design/mcv_back.sv
// Back end: stores, MAC sequencer, saturation and result register.
// Depends on mcv_pkg.
`default_nettype none
module mcv_back (
   input  wire              clock,
   input  wire              reset,
   input  wire              q_valid,
   output logic             q_take,
   input  mcv_pkg::item_type q_item,
   input  wire  [2:0]       kw_reg,
   input  wire  [5:0]       os_reg,
   input  wire  [2:0]       nm_reg,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output logic [2:0]       rsp_result_map,
   output logic [5:0]       rsp_result_row,
   output logic [5:0]       rsp_result_col,
   output logic signed [47:0] rsp_sum,
   output logic             rsp_range_error
);
   import mcv_pkg::*;

   localparam int PixD = 4 * 64 * 64;
   localparam int WgtD = 8 * 4 * 49;
   localparam logic signed [63:0] SumMax = 64'sh00007FFFFFFFFFFF;
   localparam logic signed [63:0] SumMin = -SumMax - 64'sd1;

   typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN1, S_DRAIN2, S_FINISH, S_OUT} state_type;

   logic [15:0] pix_mem [PixD];
   logic [15:0] wgt_mem [WgtD];
   logic [31:0] bias_ff [8];
   logic [7:0]  bias_ok_ff;

   state_type   state_ff;
   item_type    cur_ff;
   logic [2:0]  kw_ff, nm_ff;
   logic [1:0]  c_ff;
   logic [2:0]  i_ff, j_ff;
   logic        last_issue;
   logic        tap_ok, tap_ok_ff, tap_ok2_ff;
   logic [15:0] pix_rd_ff, wgt_rd_ff;
   logic signed [31:0] prod_ff;
   logic signed [63:0] acc_ff;
   logic [6:0]  pr, pc;
   logic [13:0] pix_wa, pix_ra;
   logic [10:0] wgt_wa, wgt_ra;
   logic [2:0]  kw_c, nm_c;
   logic [5:0]  os_c;
   logic        err;
   logic signed [63:0] total;

   // clamp registers into range
   always_comb begin
      kw_c = (kw_reg == 3'd0) ? 3'd1 : kw_reg;
      nm_c = (nm_reg == 3'd0) ? 3'd1 : ((nm_reg > 3'd4) ? 3'd4 : nm_reg);
      os_c = (os_reg == 6'd0) ? 6'd1 : ((os_reg > 6'd32) ? 6'd32 : os_reg);
      err  = (q_item.row >= os_c) || (q_item.col >= os_c);
   end

   assign pix_wa = {q_item.in_map, q_item.row, q_item.col};
   assign wgt_wa = 11'(((({8'd0, q_item.out_map} * 11'd4 + {9'd0, q_item.in_map}) * 11'd7
                   + {8'd0, q_item.row[2:0]}) * 11'd7) + {8'd0, q_item.col[2:0]});
   assign pr = {1'b0, cur_ff.row} + {4'd0, i_ff};
   assign pc = {1'b0, cur_ff.col} + {4'd0, j_ff};
   assign tap_ok = !pr[6] && !pc[6];
   assign pix_ra = {c_ff, pr[5:0], pc[5:0]};
   assign wgt_ra = 11'(((({8'd0, cur_ff.out_map} * 11'd4 + {9'd0, c_ff}) * 11'd7
                   + {8'd0, i_ff}) * 11'd7) + {8'd0, j_ff});
   assign last_issue = (j_ff == kw_ff - 3'd1) && (i_ff == kw_ff - 3'd1)
                       && ({1'b0, c_ff} == nm_ff - 3'd1);
   assign q_take = (state_ff == S_IDLE);
   assign total  = acc_ff + 64'(signed'(bias_ok_ff[cur_ff.out_map] ?
                   bias_ff[cur_ff.out_map] : 32'd0));

   // write stores
   always_ff @(posedge clock) begin
      if (q_valid && q_take) begin
         if (q_item.command == CMD_PIXEL) pix_mem[pix_wa] <= q_item.value[15:0];
         if (q_item.command == CMD_WEIGHT && q_item.row < 6'd7 && q_item.col < 6'd7)
            wgt_mem[wgt_wa] <= q_item.value[15:0];
         if (q_item.command == CMD_BIAS) bias_ff[q_item.out_map] <= q_item.value;
      end
      pix_rd_ff <= pix_mem[pix_ra];
      wgt_rd_ff <= wgt_mem[wgt_ra];
   end

   // sequence taps and accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid <= 1'b0; bias_ok_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (q_valid) begin
               if (q_item.command == CMD_BIAS) bias_ok_ff[q_item.out_map] <= 1'b1;
               if (q_item.command == CMD_CALC) begin
                  cur_ff <= q_item;
                  kw_ff <= kw_c; nm_ff <= nm_c;
                  c_ff <= '0; i_ff <= '0; j_ff <= '0;
                  acc_ff <= '0; tap_ok_ff <= 1'b0; tap_ok2_ff <= 1'b0;
                  rsp_range_error <= err;
                  state_ff <= err ? S_FINISH : S_ISSUE;
               end
            end
            S_ISSUE: begin
               tap_ok_ff <= tap_ok;
               if (last_issue) state_ff <= S_DRAIN1;
               else if (j_ff == kw_ff - 3'd1) begin
                  j_ff <= '0;
                  if (i_ff == kw_ff - 3'd1) begin i_ff <= '0; c_ff <= c_ff + 2'd1; end
                  else i_ff <= i_ff + 3'd1;
               end else j_ff <= j_ff + 3'd1;
            end
            S_DRAIN1: begin tap_ok_ff <= 1'b0; state_ff <= S_DRAIN2; end
            S_DRAIN2: state_ff <= S_FINISH;
            S_FINISH: begin
               rsp_result_map <= cur_ff.out_map;
               rsp_result_row <= cur_ff.row;
               rsp_result_col <= cur_ff.col;
               if (rsp_range_error) rsp_sum <= '0;
               else if (total > SumMax) rsp_sum <= SumMax[47:0];
               else if (total < SumMin) rsp_sum <= SumMin[47:0];
               else rsp_sum <= total[47:0];
               rsp_valid <= 1'b1;
               state_ff <= S_OUT;
            end
            S_OUT: if (!rsp_stall) begin rsp_valid <= 1'b0; state_ff <= S_IDLE; end
            default: state_ff <= S_IDLE;
         endcase
         // two-stage MAC pipeline behind the read
         if (state_ff != S_IDLE) begin
            tap_ok2_ff <= tap_ok_ff;
            prod_ff <= tap_ok_ff ? signed'(pix_rd_ff) * signed'(wgt_rd_ff) : 32'sd0;
            if (tap_ok2_ff || state_ff == S_DRAIN2 || state_ff == S_DRAIN1)
               acc_ff <= acc_ff + 64'(prod_ff);
         end
      end
   end

   out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   valid_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_OUT)) else $error("valid outside output");
   err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_sum == '0)) else $error("error sum nonzero");
endmodule
`default_nettype wire

// File: design/multichannel_conv2d_valid.sv
// Top level of the multichannel convolution engine.
// Depends on mcv_pkg, mcv_front, mcv_back.
//
// channel | direction | handshake
// req_    | in        | req_valid / req_stall
// rsp_    | out       | rsp_valid / rsp_stall
// csr_    | in        | csr_write_enable, no wait
//
// Writes are accepted by the back end only while it is idle. A compute is sequenced
// through one shared multiply-accumulate fed from one read port per store.
// Reset is synchronous; stores keep contents, bias reads zero until written.
// A four-beat queue lets req_ keep flowing while rsp_ stalls.
`default_nettype none
module multichannel_conv2d_valid (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_command,
   input  wire  [1:0]  req_in_map,
   input  wire  [2:0]  req_out_map,
   input  wire  [5:0]  req_row,
   input  wire  [5:0]  req_col,
   input  wire  [31:0] req_value,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_result_map,
   output logic [5:0]  rsp_result_row,
   output logic [5:0]  rsp_result_col,
   output logic signed [47:0] rsp_sum,
   output logic        rsp_range_error,
   input  wire         csr_write_enable,
   input  wire  [1:0]  csr_index,
   input  wire  [5:0]  csr_data
);
   import mcv_pkg::*;

   item_type   req_item, q_item;
   logic       q_valid, q_take;
   logic [2:0] kw_ff, nm_ff;
   logic [5:0] os_ff;

   assign req_item = '{command: cmd_type'(req_command), in_map: req_in_map,
                       out_map: req_out_map, row: req_row, col: req_col, value: req_value};

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kw_ff <= 3'd3; os_ff <= 6'd32; nm_ff <= 3'd1;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_KERNEL) kw_ff <= csr_data[2:0];
         if (csr_index == CSR_SIDE)   os_ff <= csr_data;
         if (csr_index == CSR_MAPS)   nm_ff <= csr_data[2:0];
      end
   end

   mcv_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_stall(req_stall),
      .in_item(req_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
   );

   mcv_back u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_take(q_take),
      .q_item(q_item), .kw_reg(kw_ff), .os_reg(os_ff), .nm_reg(nm_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_map(rsp_result_map),
      .rsp_result_row(rsp_result_row), .rsp_result_col(rsp_result_col),
      .rsp_sum(rsp_sum), .rsp_range_error(rsp_range_error)
   );
endmodule
`default_nettype wire

// File: dv/multichannel_conv2d_valid_test.sv
// Self-checking testbench for the multichannel convolution engine.
// Depends on mcv_pkg and multichannel_conv2d_valid; predicts each compute beat.
`timescale 1ns / 100ps
module multichannel_conv2d_valid_test;
   import mcv_pkg::*;

   localparam int N_IN = 4, N_OUT = 8, N_K = 7, N_SIDE = 32, N_PIX = 64;
   localparam logic signed [63:0] SUM_HI = 64'sh00007FFFFFFFFFFF;
   localparam logic signed [63:0] SUM_LO = -SUM_HI - 1;
   localparam int IDLE_LIMIT = 20000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [2:0]  map;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [47:0] sum;
      logic        err;
   } point_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [1:0] req_command = 0;
   logic [1:0] req_in_map = 0;
   logic [2:0] req_out_map = 0;
   logic [5:0] req_row = 0, req_col = 0;
   logic [31:0] req_value = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [2:0] rsp_result_map;
   logic [5:0] rsp_result_row, rsp_result_col;
   logic signed [47:0] rsp_sum;
   logic rsp_range_error;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = 0;
   logic [5:0] csr_data = 0;

   // predictor state
   logic [15:0] pixel_mem [N_IN][N_PIX][N_PIX];
   logic        pixel_set [N_IN][N_PIX][N_PIX];
   logic [15:0] weight_mem [N_OUT][N_IN][N_K][N_K];
   logic        weight_set [N_OUT][N_IN][N_K][N_K];
   logic [31:0] bias_mem [N_OUT];
   logic [2:0]  kw_reg, maps_reg;
   logic [5:0]  side_reg;

   point_type expected_points [$];
   int failures = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   logic hold_rsp = 0;

   multichannel_conv2d_valid u_dut (.*);

   always #10 clock = ~clock;

   // watchdog: count cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle_pct);
   end

   // check each result beat against the oldest prediction
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result beat map %0d row %0d col %0d",
                   rsp_result_map, rsp_result_row, rsp_result_col);
            failures++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_result_map !== e.map) begin
               $error("result_map exp %0d got %0d", e.map, rsp_result_map); failures++;
            end
            if (rsp_result_row !== e.row) begin
               $error("result_row exp %0d got %0d", e.row, rsp_result_row); failures++;
            end
            if (rsp_result_col !== e.col) begin
               $error("result_col exp %0d got %0d", e.col, rsp_result_col); failures++;
            end
            if (rsp_sum !== e.sum) begin
               $error("sum exp %h got %h", e.sum, rsp_sum); failures++;
            end
            if (rsp_range_error !== e.err) begin
               $error("range_error exp %0d got %0d", e.err, rsp_range_error); failures++;
            end
         end
      end
   end

   function automatic int clamp_field(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // whether a compute would read only written entries
   function automatic bit window_written(int m, int r, int c);
      int kw, nm;
      kw = clamp_field(kw_reg, N_K);
      nm = clamp_field(maps_reg, N_IN);
      if (m >= N_OUT || r >= clamp_field(side_reg, N_SIDE) || c >= clamp_field(side_reg, N_SIDE))
         return 1;
      for (int ch = 0; ch < nm; ch++)
         for (int i = 0; i < kw; i++)
            for (int j = 0; j < kw; j++) begin
               if (r + i >= N_PIX || c + j >= N_PIX) continue;
               if (!pixel_set[ch][r+i][c+j] || !weight_set[m][ch][i][j]) return 0;
            end
      return 1;
   endfunction

   // update stores or compute the expected output point
   function automatic void predict_command(item_type it);
      point_type p;
      logic signed [63:0] acc;
      int kw, nm, os;
      case (it.command)
         CMD_PIXEL: begin
            pixel_mem[it.in_map][it.row][it.col] = it.value[15:0];
            pixel_set[it.in_map][it.row][it.col] = 1;
         end
         CMD_WEIGHT: begin
            if (it.row < N_K && it.col < N_K) begin
               weight_mem[it.out_map][it.in_map][it.row][it.col] = it.value[15:0];
               weight_set[it.out_map][it.in_map][it.row][it.col] = 1;
            end
         end
         CMD_BIAS: bias_mem[it.out_map] = it.value;
         default: begin
            kw = clamp_field(kw_reg, N_K);
            os = clamp_field(side_reg, N_SIDE);
            nm = clamp_field(maps_reg, N_IN);
            p.map = it.out_map; p.row = it.row; p.col = it.col;
            p.err = !(it.row < os && it.col < os);
            acc = 0;
            if (!p.err) begin
               for (int ch = 0; ch < nm; ch++)
                  for (int i = 0; i < kw; i++)
                     for (int j = 0; j < kw; j++) begin
                        if (it.row + i >= N_PIX || it.col + j >= N_PIX) continue;
                        acc += $signed(pixel_mem[ch][it.row+i][it.col+j]) *
                               $signed(weight_mem[it.out_map][ch][i][j]);
                     end
               acc += $signed(bias_mem[it.out_map]);
               if (acc > SUM_HI) acc = SUM_HI;
               if (acc < SUM_LO) acc = SUM_LO;
            end
            p.sum = p.err ? 48'd0 : acc[47:0];
            expected_points.push_back(p);
         end
      endcase
   endfunction

   // offer one beat and hold it until accepted; valid stays high for a following beat
   task automatic send_command(item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_command <= it.command; req_in_map <= it.in_map; req_out_map <= it.out_map;
      req_row <= it.row; req_col <= it.col; req_value <= it.value;
      do @(posedge clock); while (req_stall);
      predict_command(it);
   endtask

   task automatic send_fields(cmd_type cmd, int im, int om, int r, int c, logic [31:0] v);
      item_type it;
      it.command = cmd; it.in_map = 2'(im); it.out_map = 3'(om);
      it.row = 6'(r); it.col = 6'(c); it.value = v;
      send_command(it);
   endtask

   // computes only when every entry read has been written
   task automatic send_compute(int om, int r, int c);
      if (window_written(om, r, c)) send_fields(CMD_CALC, $urandom_range(3), om, r, c, $urandom);
   endtask

   // drop valid, wait until nothing is expected, then let the engine settle
   task automatic drain();
      req_valid <= 0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (N_IN * N_K * N_K + 20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [5:0] data);
      csr_write_enable <= 1; csr_index <= idx; csr_data <= data;
      @(posedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_KERNEL: kw_reg = data[2:0];
         CSR_SIDE:   side_reg = data;
         CSR_MAPS:   maps_reg = data[2:0];
         default: ;
      endcase
   endtask

   task automatic set_shape(int kw, int os, int nm);
      drain();
      write_csr(CSR_KERNEL, 6'(kw));
      write_csr(CSR_SIDE, 6'(os));
      write_csr(CSR_MAPS, 6'(nm));
   endtask

   // fill the weights of the first n_out maps and a pixel region
   task automatic fill_region(int pix_side, logic extreme, int n_out);
      for (int m = 0; m < n_out; m++)
         for (int ch = 0; ch < N_IN; ch++)
            for (int i = 0; i < N_K; i++)
               for (int j = 0; j < N_K; j++)
                  if (!weight_set[m][ch][i][j])
                     send_fields(CMD_WEIGHT, ch, m, i, j,
                                 extreme ? 32'h8000 : $urandom);
      for (int ch = 0; ch < N_IN; ch++)
         for (int r = 0; r < pix_side; r++)
            for (int c = 0; c < pix_side; c++)
               if (!pixel_set[ch][r][c])
                  send_fields(CMD_PIXEL, ch, $urandom_range(7), r, c,
                              extreme ? 32'h8000 : $urandom);
   endtask

   task automatic test_directed();
      set_shape(1, 32, 1);
      // extreme operands and biases of both signs
      send_fields(CMD_PIXEL, 0, 0, 0, 0, 32'hFFFF8000);
      send_fields(CMD_WEIGHT, 0, 0, 0, 0, 32'h00008000);
      send_fields(CMD_BIAS, 0, 0, 0, 0, 32'h7FFFFFFF);
      send_compute(0, 0, 0);
      send_fields(CMD_BIAS, 0, 7, 0, 0, 32'h80000000);
      send_fields(CMD_WEIGHT, 0, 7, 0, 0, 32'h00007FFF);
      send_compute(7, 0, 0);
      // out-of-range weight writes are dropped
      send_fields(CMD_WEIGHT, 0, 0, 7, 63, 32'h1234);
      send_fields(CMD_WEIGHT, 0, 0, 63, 0, 32'h1234);
      send_compute(0, 0, 0);
      // out-of-range computes report range_error
      send_fields(CMD_CALC, 0, 3, 32, 0, 0);
      send_fields(CMD_CALC, 0, 3, 0, 63, 0);
      send_fields(CMD_CALC, 0, 3, 63, 63, 0);
      // pixel at the far corner
      send_fields(CMD_PIXEL, 3, 0, 63, 63, 32'h0000FFFF);
      // registers out of range clamp; unknown index is ignored
      drain();
      write_csr(CSR_KERNEL, 0);
      write_csr(CSR_SIDE, 0);
      write_csr(CSR_MAPS, 7);
      write_csr(CSR_UNUSED, 6'h3F);
      send_compute(0, 0, 0);
      send_fields(CMD_CALC, 0, 0, 1, 0, 0);
      set_shape(7, 63, 0);
      send_fields(CMD_CALC, 0, 1, 32, 32, 0);
   endtask

   // largest window with all-minimum operands
   task automatic test_saturation();
      set_shape(7, 2, 4);
      fill_region(8, 1, 1);
      send_fields(CMD_BIAS, 0, 0, 0, 0, 32'h7FFFFFFF);
      for (int k = 0; k < 4; k++) send_compute(0, k % 2, k / 2);
   endtask

   // random traffic under a given shape
   task automatic random_phase(int kw, int os, int nm, int n);
      int lim;
      item_type it;
      set_shape(kw, os, nm);
      lim = clamp_field(os, N_SIDE) + clamp_field(kw, N_K);
      for (int k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1: begin
               it.command = CMD_PIXEL; it.in_map = 2'($urandom); it.out_map = 3'($urandom);
               it.row = 6'($urandom_range(lim - 1)); it.col = 6'($urandom);
               it.value = $urandom;
               send_command(it);
            end
            2: send_fields(CMD_WEIGHT, $urandom, $urandom, $urandom_range(8), $urandom,
                           $urandom);
            3: send_fields(CMD_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom);
            9: send_compute($urandom_range(7), $urandom_range(63), $urandom_range(63));
            default: send_compute(($urandom_range(3) == 0) ? int'($urandom_range(7)) : 0,
                                  $urandom_range(os), $urandom_range(os));
         endcase
      end
   endtask

   // long receiver hold while the sender keeps offering computes
   task automatic test_backpressure();
      set_shape(1, 8, 1);
      fork
         begin
            hold_rsp = 1;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end
         for (int k = 0; k < 12; k++) send_compute(0, k % 8, 0);
      join
      drain();
   endtask

   initial begin
      for (int m = 0; m < N_OUT; m++) bias_mem[m] = 0;
      for (int ch = 0; ch < N_IN; ch++)
         for (int r = 0; r < N_PIX; r++)
            for (int c = 0; c < N_PIX; c++) pixel_set[ch][r][c] = 0;
      for (int m = 0; m < N_OUT; m++)
         for (int ch = 0; ch < N_IN; ch++)
            for (int i = 0; i < N_K; i++)
               for (int j = 0; j < N_K; j++) weight_set[m][ch][i][j] = 0;
      kw_reg = 3; side_reg = 32; maps_reg = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle_pct = 24; recv_idle_pct = 83;
      test_directed();
      test_saturation();
      random_phase(3, 4, 2, 200);
      send_idle_pct = 83; recv_idle_pct = 24;
      random_phase(1, 1, 1, 100);
      random_phase(7, 2, 4, 80);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(2, 7, 3, 150);
      test_backpressure();
      random_phase(5, 3, 4, 80);

      drain();
      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
